FILE: src/sims_pkg.sv
// Shared types, constants and the bucket hash for the sparse swap block.
package sims_pkg;

    localparam int unsigned BUCKETS_DEF = 1024;
    localparam int unsigned WAYS_DEF = 4;
    localparam logic [31:0] MIX_MUL = 32'h045d9f3b;

    typedef struct packed {
        logic signed [31:0] first_index;
        logic signed [31:0] second_index;
    } t_in;

    typedef struct packed {
        logic [31:0] difference;
        logic table_full;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_READ1,
        ST_READ2,
        ST_DECIDE,
        ST_WRITE1,
        ST_WRITE2,
        ST_OUT
    } t_state;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hash1;
        logic hash2;
        logic hash3;
        logic read1;
        logic read2;
        logic decide;
        logic write1;
        logic write2;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic equal;
        logic clearing;
    } t_sts;

    function automatic logic [31:0] mix_half(input logic [31:0] x);
        mix_half = {{16{x[31]}}, x[31:16]} ^ x;
    endfunction

endpackage

FILE: src/sims_ctrl.sv
// Controller state machine that sequences hashing, lookups and writes.
module sims_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sims_pkg::t_sts    i_sts,
    output sims_pkg::t_cmd    o_cmd
);

    sims_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sims_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sims_pkg::ST_IDLE:   if (i_in_valid && !i_sts.clearing) n_state = sims_pkg::ST_HASH1;
            sims_pkg::ST_HASH1:  n_state = sims_pkg::ST_HASH2;
            sims_pkg::ST_HASH2:  n_state = sims_pkg::ST_HASH3;
            sims_pkg::ST_HASH3:  n_state = i_sts.equal ? sims_pkg::ST_OUT : sims_pkg::ST_READ1;
            sims_pkg::ST_READ1:  n_state = sims_pkg::ST_READ2;
            sims_pkg::ST_READ2:  n_state = sims_pkg::ST_DECIDE;
            sims_pkg::ST_DECIDE: n_state = sims_pkg::ST_WRITE1;
            sims_pkg::ST_WRITE1: n_state = sims_pkg::ST_WRITE2;
            sims_pkg::ST_WRITE2: n_state = sims_pkg::ST_OUT;
            sims_pkg::ST_OUT:    if (i_out_ready) n_state = sims_pkg::ST_IDLE;
            default:             n_state = sims_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sims_pkg::ST_IDLE: begin
                o_in_ready = !i_sts.clearing;
                o_cmd.load = i_in_valid && !i_sts.clearing;
            end
            sims_pkg::ST_HASH1:  o_cmd.hash1 = 1'b1;
            sims_pkg::ST_HASH2:  o_cmd.hash2 = 1'b1;
            sims_pkg::ST_HASH3:  o_cmd.hash3 = 1'b1;
            sims_pkg::ST_READ1:  o_cmd.read1 = 1'b1;
            sims_pkg::ST_READ2:  o_cmd.read2 = 1'b1;
            sims_pkg::ST_DECIDE: o_cmd.decide = 1'b1;
            sims_pkg::ST_WRITE1: o_cmd.write1 = 1'b1;
            sims_pkg::ST_WRITE2: o_cmd.write2 = 1'b1;
            sims_pkg::ST_OUT:    o_out_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.hash1) else $error("hash did not follow load");
`endif

endmodule

FILE: src/sims_dp.sv
// Datapath: hash unit, bucket memories, way search and swap update.
module sims_dp #(
    parameter int unsigned BUCKETS = sims_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS = sims_pkg::WAYS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sims_pkg::t_in   i_in,
    input  sims_pkg::t_cmd  i_cmd,
    output sims_pkg::t_sts  o_sts,
    output sims_pkg::t_out  o_out
);

    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    // One memory row per bucket: all ways' keys and values side by side.
    logic [WAYS*32-1:0] r_key_mem [BUCKETS];
    logic [WAYS*32-1:0] r_val_mem [BUCKETS];
    logic [WAYS-1:0]    r_vld [BUCKETS];

    logic [31:0] r_k1, r_k2, r_x1, r_x2;
    logic [BW-1:0] r_b1, r_b2;
    logic [WAYS*32-1:0] r_rkey, r_rval;
    logic [WAYS-1:0] r_rvld;
    logic [WAYS*32-1:0] r_key1, r_val1;
    logic [WAYS-1:0] r_vld1;
    logic [31:0] r_v1, r_v2;
    logic [WW-1:0] r_w1, r_w2;
    logic r_full, r_equal;
    logic [31:0] r_diff;
    logic r_clr_busy;
    logic [BW-1:0] r_clr_addr;

    logic [WAYS-1:0] hit1, hit2;
    logic found1, found2, free1_ok, free2_ok, same_b;
    logic [WW-1:0] hw1, hw2, fw1, fw2;
    logic [31:0] v1, v2;
    logic [WAYS-1:0] vld2_eff;
    logic [BW-1:0] rd_addr;

    // The first bucket row is held in r_key1 and friends; the second is still
    // in the read registers while the decision is taken.
    always_comb begin
        hit1 = '0;
        hit2 = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit1[w] = r_vld1[w] && (r_key1[w*32 +: 32] == r_k1);
            hit2[w] = r_rvld[w] && (r_rkey[w*32 +: 32] == r_k2);
        end
    end

    always_comb begin
        hw1 = '0; hw2 = '0; fw1 = '0; fw2 = '0;
        found1 = 1'b0; found2 = 1'b0; free1_ok = 1'b0; free2_ok = 1'b0;
        v1 = r_k1; v2 = r_k2;
        same_b = (r_b1 == r_b2);
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit1[w]) begin
                found1 = 1'b1; hw1 = WW'(w); v1 = r_val1[w*32 +: 32];
            end
            if (hit2[w]) begin
                found2 = 1'b1; hw2 = WW'(w); v2 = r_rval[w*32 +: 32];
            end
            if (!r_vld1[w]) begin
                free1_ok = 1'b1; fw1 = WW'(w);
            end
        end
        vld2_eff = r_rvld;
        if (same_b && !found1 && free1_ok) vld2_eff[fw1] = 1'b1;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!vld2_eff[w]) begin
                free2_ok = 1'b1; fw2 = WW'(w);
            end
        end
    end

    assign rd_addr = i_cmd.read1 ? r_b1 : r_b2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read1 || i_cmd.read2) begin
            r_rkey <= r_key_mem[rd_addr];
            r_rval <= r_val_mem[rd_addr];
        end
        if (i_cmd.write1 && !r_full) begin
            r_key_mem[r_b1][r_w1*32 +: 32] <= r_k1;
            r_val_mem[r_b1][r_w1*32 +: 32] <= r_v2;
        end else if (i_cmd.write2 && !r_full) begin
            r_key_mem[r_b2][r_w2*32 +: 32] <= r_k2;
            r_val_mem[r_b2][r_w2*32 +: 32] <= r_v1;
        end
    end

    // After reset the valid rows are cleared one bucket per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + BW'(1);
            if (r_clr_addr == BW'(BUCKETS - 1)) r_clr_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_vld[r_clr_addr] <= '0;
        end else if (i_cmd.write1 && !r_full) begin
            r_vld[r_b1][r_w1] <= 1'b1;
        end else if (i_cmd.write2 && !r_full) begin
            r_vld[r_b2][r_w2] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read1 || i_cmd.read2) r_rvld <= r_vld[rd_addr];
        if (i_cmd.load) begin
            r_k1 <= i_in.first_index;
            r_k2 <= i_in.second_index;
            r_x1 <= sims_pkg::mix_half(i_in.first_index);
            r_x2 <= sims_pkg::mix_half(i_in.second_index);
            r_equal <= (i_in.first_index == i_in.second_index);
        end
        if (i_cmd.hash1 || i_cmd.hash2) begin
            r_x1 <= sims_pkg::mix_half(r_x1 * sims_pkg::MIX_MUL);
            r_x2 <= sims_pkg::mix_half(r_x2 * sims_pkg::MIX_MUL);
        end
        if (i_cmd.hash2) begin
            r_b1 <= BW'((sims_pkg::mix_half(r_x1 * sims_pkg::MIX_MUL)) % BUCKETS);
            r_b2 <= BW'((sims_pkg::mix_half(r_x2 * sims_pkg::MIX_MUL)) % BUCKETS);
        end
        if (i_cmd.hash3) begin
            r_diff <= '0;
            r_full <= 1'b0;
        end
        if (i_cmd.read2) begin
            r_key1 <= r_rkey; r_val1 <= r_rval; r_vld1 <= r_rvld;
        end
        if (i_cmd.decide) begin
            r_v1 <= v1;
            r_v2 <= v2;
            r_w1 <= found1 ? hw1 : fw1;
            r_w2 <= found2 ? hw2 : fw2;
            r_full <= (!found1 && !free1_ok) || (!found2 && !free2_ok);
            r_diff <= ($signed(v1) > $signed(v2)) ? v1 - v2 : v2 - v1;
        end
    end

    assign o_sts.equal = r_equal;
    assign o_sts.clearing = r_clr_busy;
    assign o_out.difference = r_diff;
    assign o_out.table_full = r_full;

endmodule

FILE: src/sparse_identity_map_swap_top.sv
// Top level of the sparse identity-map swap block.
// The block keeps a sparse array of signed 32-bit values in which an index
// never written reads as itself. Each input transfer names two indices; the
// block returns the absolute difference of their values and swaps them,
// inserting absent indices into a hashed table of BUCKETS rows of WAYS
// entries. If an insertion finds its bucket full, nothing is written and
// table_full is set. Equal indices return zero and change nothing. One item
// is handled at a time: a full item steps from the input transfer through
// the hash states of the two-round hash, two single-port bucket reads, a
// decision and two writes to the result state, and the next input is taken
// only once the result transfer completes; equal indices go from the hash
// states straight to the result state. After reset the valid bits are
// cleared by a pass of one bucket per cycle, so the input stays not ready
// until all BUCKETS rows (1024 by default) have been cleared.
module sparse_identity_map_swap_top #(
    parameter int unsigned BUCKETS = sims_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS = sims_pkg::WAYS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sims_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sims_pkg::t_out o_out_data
);

    sims_pkg::t_cmd cmd;
    sims_pkg::t_sts sts;

    // The controller steps through the phases of one item.
    sims_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    // The datapath holds the table and computes the result.
    sims_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(i_in_data), .i_cmd(cmd), .o_sts(sts), .o_out(o_out_data)
    );

endmodule

FILE: tb/sparse_identity_map_swap_top_test.sv
// Self-checking testbench for the sparse identity-map swap block.
module sparse_identity_map_swap_top_test;

    localparam int unsigned NBUCKETS = sims_pkg::BUCKETS_DEF;
    localparam int unsigned NWAYS = sims_pkg::WAYS_DEF;
    localparam int unsigned NENTRIES = NBUCKETS * NWAYS;
    localparam int unsigned RANDOM_ITEMS = 1630;
    localparam int unsigned STALL_LIMIT = 20000;

    // The scoreboard keeps its own copy of the sparse table and a queue of
    // the results that accepted transfers are owed.
    class swap_scoreboard;
        bit              slot_used [NENTRIES];
        logic [31:0]     slot_key [NENTRIES];
        logic [31:0]     slot_value [NENTRIES];
        sims_pkg::t_out  owed_results [$];
        int unsigned     error_count;
        int unsigned     full_count;
        int unsigned     checked_count;

        function automatic logic [31:0] bucket_of(input logic [31:0] k);
            logic [31:0] x;
            x = k;
            x = (({{16{x[31]}}, x[31:16]}) ^ x) * sims_pkg::MIX_MUL;
            x = (({{16{x[31]}}, x[31:16]}) ^ x) * sims_pkg::MIX_MUL;
            x = ({{16{x[31]}}, x[31:16]}) ^ x;
            return x % NBUCKETS;
        endfunction

        function automatic int find_slot(input logic [31:0] b, input logic [31:0] k);
            for (int w = 0; w < NWAYS; w++)
                if (slot_used[b * NWAYS + w] && slot_key[b * NWAYS + w] == k)
                    return b * NWAYS + w;
            return -1;
        endfunction

        function automatic int open_slot(input logic [31:0] b, input int skip);
            int seen;
            seen = 0;
            for (int w = 0; w < NWAYS; w++)
                if (!slot_used[b * NWAYS + w]) begin
                    if (seen == skip) return b * NWAYS + w;
                    seen++;
                end
            return -1;
        endfunction

        // Works out the result of one accepted input and updates the table.
        function void note_input(input sims_pkg::t_in item);
            logic [31:0]    k1, k2, b1, b2, v1, v2;
            int             e1, e2, n1, n2;
            bit             full;
            sims_pkg::t_out res;
            k1 = item.first_index;
            k2 = item.second_index;
            full = 0;
            n1 = -1;
            n2 = -1;
            if (k1 == k2) begin
                res.difference = '0;
                res.table_full = 1'b0;
                owed_results.push_back(res);
                return;
            end
            b1 = bucket_of(k1);
            b2 = bucket_of(k2);
            e1 = find_slot(b1, k1);
            e2 = find_slot(b2, k2);
            v1 = (e1 >= 0) ? slot_value[e1] : k1;
            v2 = (e2 >= 0) ? slot_value[e2] : k2;
            if (e1 < 0) begin
                n1 = open_slot(b1, 0);
                if (n1 < 0) full = 1;
            end
            if (e2 < 0) begin
                n2 = open_slot(b2, (e1 < 0 && b1 == b2) ? 1 : 0);
                if (n2 < 0) full = 1;
            end
            if (!full) begin
                if (e1 < 0) begin
                    e1 = n1;
                    slot_used[e1] = 1;
                    slot_key[e1] = k1;
                end
                if (e2 < 0) begin
                    e2 = n2;
                    slot_used[e2] = 1;
                    slot_key[e2] = k2;
                end
                slot_value[e1] = v2;
                slot_value[e2] = v1;
            end
            // Signed compare, unsigned wrapped difference.
            res.difference = ($signed(v1) > $signed(v2)) ? v1 - v2 : v2 - v1;
            res.table_full = full;
            if (full) full_count++;
            owed_results.push_back(res);
        endfunction

        function void check_result(input sims_pkg::t_out got);
            sims_pkg::t_out want;
            checked_count++;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h/%b",
                         $time, got.difference, got.table_full);
                error_count++;
                return;
            end
            want = owed_results.pop_front();
            if (got.difference !== want.difference) begin
                $display("%0t: difference mismatch: expected %h, actual %h",
                         $time, want.difference, got.difference);
                error_count++;
            end
            if (got.table_full !== want.table_full) begin
                $display("%0t: table_full mismatch: expected %b, actual %b",
                         $time, want.table_full, got.table_full);
                error_count++;
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    sims_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    sims_pkg::t_out o_out_data;

    swap_scoreboard board;
    bit             calm_phase;
    int unsigned    idle_cycles;
    int unsigned    sent_count;

    sparse_identity_map_swap_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Returns 1 when a side should sit idle this cycle: about 29 percent of
    // the time, except during the calm stretch where both run flat out.
    function automatic bit want_idle();
        return !calm_phase && ($urandom_range(99) < 29);
    endfunction

    // Sends one index pair. Valid is held, with the payload steady, until the
    // transfer is taken. Random idle cycles go in before valid rises.
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        while (want_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data.first_index <= a;
        i_in_data.second_index <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_input('{first_index: a, second_index: b});
        sent_count++;
    endtask

    // Result side: ready toggles at random, and every transfer is checked
    // at the edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_result(o_out_data);
            i_out_ready <= !want_idle();
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Random index drawn from a small pool so that keys repeat, buckets fill
    // up and values move around; sometimes a fully random index or one near the signed extremes instead.
    function automatic logic [31:0] pick_index(input int unsigned pool_size);
        logic [31:0] k;
        case ($urandom_range(9))
            0: k = $urandom;
            1: k = 32'h8000_0000 + $urandom_range(3);
            2: k = 32'h7fff_fffc + $urandom_range(3);
            default: k = $urandom_range(pool_size) - pool_size / 2;
        endcase
        return k;
    endfunction

    // Finds n distinct keys that share the bucket of seed, for bucket-full cases.
    task automatic collide_keys(input logic [31:0] seed, input int n,
                                output logic [31:0] keys [$]);
        logic [31:0] b, k;
        b = board.bucket_of(seed);
        keys = {};
        k = seed;
        while (keys.size() < n) begin
            if (board.bucket_of(k) == b) keys.push_back(k);
            k = k + 1;
        end
    endtask

    initial begin
        logic [31:0] group [$];
        logic [31:0] a, b;
        board = new();
        calm_phase = 1'b0;
        idle_cycles = 0;
        sent_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes of both fields, equal indices, swaps of
        // already present keys, and one bucket driven to full.
        send_pair(32'h8000_0000, 32'h7fff_ffff);
        send_pair(32'h7fff_ffff, 32'h8000_0000);
        send_pair(32'h0000_0000, 32'hffff_ffff);
        send_pair(32'h5555_5555, 32'haaaa_aaaa);
        send_pair(32'h1234_5678, 32'h1234_5678);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h0000_0000, 32'h8000_0000);
        send_pair(32'h7fff_ffff, 32'hffff_ffff);
        collide_keys(32'h0000_0100, 6, group);
        // Both absent and sharing a bucket, then fill it up, then overflow.
        send_pair(group[0], group[1]);
        send_pair(group[2], group[3]);
        send_pair(group[4], group[0]);
        send_pair(group[4], group[5]);
        send_pair(group[1], group[2]);
        send_pair(group[3], group[3]);
        send_pair(group[0], 32'h0000_0000);

        // Random part: a calm stretch with no idling in the middle.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm_phase = (i >= 600 && i < 800);
            if (i % 200 == 100) begin
                // Occasionally overfill a fresh bucket.
                collide_keys($urandom, NWAYS + 2, group);
                for (int j = 0; j + 1 < group.size(); j += 2)
                    send_pair(group[j], group[j + 1]);
                send_pair(group[0], group[group.size() - 1]);
            end
            a = pick_index(i < 800 ? 64 : 4000);
            b = ($urandom_range(19) == 0) ? a : pick_index(i < 800 ? 64 : 4000);
            send_pair(a, b);
        end
        i_in_valid <= 1'b0;
        calm_phase = 1'b0;

        while (board.owed_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Ran %0d index pairs and checked %0d results, %0d of them with a full bucket.",
                 sent_count, board.checked_count, board.full_count);
        if (board.error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
